@@ design/owtr_pkg.sv @@
// shared types, constants and helpers for the one-wire temperature reader
package owtr_pkg;

  localparam int TickW = 24;
  localparam int SkipDepth = 5;
  localparam int CfgIdxW = 3;

  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_DELAY = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_POST_PRESENCE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DELAY = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONVERSION_WAIT = 3'd5;

  localparam logic [12:0] DivHundredMul = 13'd5243;

  typedef enum logic [24:0] {
    PH_R1L   = 25'h0000001,
    PH_R1W   = 25'h0000002,
    PH_R1P   = 25'h0000004,
    PH_R1H   = 25'h0000008,
    PH_WA_L  = 25'h0000010,
    PH_WA_H  = 25'h0000020,
    PH_WB_L  = 25'h0000040,
    PH_WB_H  = 25'h0000080,
    PH_CONV  = 25'h0000100,
    PH_R2L   = 25'h0000200,
    PH_R2W   = 25'h0000400,
    PH_R2P   = 25'h0000800,
    PH_R2H   = 25'h0001000,
    PH_WC_L  = 25'h0002000,
    PH_WC_H  = 25'h0004000,
    PH_WD_L  = 25'h0008000,
    PH_WD_H  = 25'h0010000,
    PH_RD0_L = 25'h0020000,
    PH_RD0_D = 25'h0040000,
    PH_RD0_S = 25'h0080000,
    PH_RD0_H = 25'h0100000,
    PH_RD1_L = 25'h0200000,
    PH_RD1_D = 25'h0400000,
    PH_RD1_S = 25'h0800000,
    PH_RD1_H = 25'h1000000
  } phase_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_delay_ticks;
    logic [15:0] post_presence_ticks;
    logic [15:0] slot_ticks;
    logic [7:0]  sample_delay_ticks;
    logic [23:0] conversion_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic settle;
  } seq_ctrl_t;

  typedef struct packed {
    logic        drive_low;
    logic        reading_valid;
    logic [15:0] tenths_value;
  } tick_res_t;

  // remainder below 100 split into units and tenths digits
  function automatic logic [7:0] digit_split(input logic [6:0] r);
    logic [3:0] u;
    logic [6:0] rest;
    u = '0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 7'(10 * k)) u = 4'(k);
    end
    rest = r - 7'({u, 3'b000}) - 7'({u, 1'b0});
    return {u, rest[3:0]};
  endfunction

endpackage

@@ design/owtr_seq.sv @@
// bus sequencer: phase state, slot timing, bit shifting and the tick result register
module owtr_seq (
  input  logic                clk,
  input  logic                rst,
  input  owtr_pkg::cfg_t      cfg,
  input  owtr_pkg::seq_ctrl_t ctrl,
  input  logic                bus_level,
  input  logic                a_ready,
  output logic                a_valid,
  output owtr_pkg::tick_res_t a_res
);
  import owtr_pkg::*;

  typedef struct packed {
    phase_t           phase;
    logic [TickW-1:0] tick_count;
    logic [2:0]       bit_index;
    logic [7:0]       shift_byte;
    logic [7:0]       low_byte;
  } seq_state_t;

  typedef struct packed {
    seq_state_t st;
    logic       done;
  } skip_t;

  seq_state_t  st;
  seq_state_t  stepped;
  seq_state_t  chain_in;
  skip_t       pres_adv;
  skip_t       chain;
  logic [15:0] held;
  logic [15:0] cand;
  logic        pending;

  function automatic logic [TickW-1:0] phase_len(input seq_state_t s, input cfg_t c);
    logic one;
    logic [TickW-1:0] len;
    one = s.shift_byte[0];
    unique case (s.phase)
      PH_R1L, PH_R2L: len = TickW'(c.reset_low_ticks);
      PH_R1W, PH_R2W: len = TickW'(c.presence_delay_ticks);
      PH_R1H, PH_R2H: len = TickW'(c.post_presence_ticks);
      PH_WA_L, PH_WB_L, PH_WC_L, PH_WD_L:
        len = one ? TickW'(1) : TickW'(c.slot_ticks);
      PH_WA_H, PH_WB_H, PH_WC_H, PH_WD_H:
        len = one ? TickW'(c.slot_ticks) : TickW'(2);
      PH_CONV: len = c.conversion_wait_ticks;
      PH_RD0_L, PH_RD1_L, PH_RD0_S, PH_RD1_S: len = TickW'(1);
      PH_RD0_D, PH_RD1_D: len = TickW'(c.sample_delay_ticks);
      PH_RD0_H, PH_RD1_H: len = TickW'(c.slot_ticks);
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic drives_low(input phase_t ph);
    logic low;
    unique case (ph)
      PH_R1L, PH_R2L, PH_RD0_L, PH_RD1_L,
      PH_WA_L, PH_WB_L, PH_WC_L, PH_WD_L: low = 1'b1;
      default: low = 1'b0;
    endcase
    return low;
  endfunction

  function automatic seq_state_t start_byte(input seq_state_t s, input phase_t ph,
                                            input logic [7:0] v);
    seq_state_t r;
    r = s;
    r.phase = ph;
    r.shift_byte = v;
    r.bit_index = '0;
    return r;
  endfunction

  function automatic skip_t advance(input seq_state_t s);
    skip_t r;
    logic [2:0] nb;
    r.st = s;
    r.done = 1'b0;
    r.st.tick_count = '0;
    nb = s.bit_index + 3'd1;
    unique case (s.phase)
      PH_R1L: r.st.phase = PH_R1W;
      PH_R1W: r.st.phase = PH_R1P;
      PH_R1P: r.st.phase = PH_R1H;
      PH_R1H: r.st = start_byte(r.st, PH_WA_L, CMD_SKIP_ROM);
      PH_WA_L: r.st.phase = PH_WA_H;
      PH_WB_L: r.st.phase = PH_WB_H;
      PH_WC_L: r.st.phase = PH_WC_H;
      PH_WD_L: r.st.phase = PH_WD_H;
      PH_WA_H: begin
        r.st.bit_index = nb;
        if (nb != '0) begin
          r.st.shift_byte = s.shift_byte >> 1;
          r.st.phase = PH_WA_L;
        end else begin
          r.st = start_byte(r.st, PH_WB_L, CMD_CONVERT);
        end
      end
      PH_WB_H: begin
        r.st.bit_index = nb;
        if (nb != '0) begin
          r.st.shift_byte = s.shift_byte >> 1;
          r.st.phase = PH_WB_L;
        end else begin
          r.st.phase = PH_CONV;
        end
      end
      PH_CONV: r.st.phase = PH_R2L;
      PH_R2L: r.st.phase = PH_R2W;
      PH_R2W: r.st.phase = PH_R2P;
      PH_R2P: r.st.phase = PH_R2H;
      PH_R2H: r.st = start_byte(r.st, PH_WC_L, CMD_SKIP_ROM);
      PH_WC_H: begin
        r.st.bit_index = nb;
        if (nb != '0) begin
          r.st.shift_byte = s.shift_byte >> 1;
          r.st.phase = PH_WC_L;
        end else begin
          r.st = start_byte(r.st, PH_WD_L, CMD_READ_SCRATCH);
        end
      end
      PH_WD_H: begin
        r.st.bit_index = nb;
        if (nb != '0) begin
          r.st.shift_byte = s.shift_byte >> 1;
          r.st.phase = PH_WD_L;
        end else begin
          r.st = start_byte(r.st, PH_RD0_L, 8'h00);
        end
      end
      PH_RD0_L: r.st.phase = PH_RD0_D;
      PH_RD0_D: r.st.phase = PH_RD0_S;
      PH_RD0_S: r.st.phase = PH_RD0_H;
      PH_RD1_L: r.st.phase = PH_RD1_D;
      PH_RD1_D: r.st.phase = PH_RD1_S;
      PH_RD1_S: r.st.phase = PH_RD1_H;
      PH_RD0_H: begin
        r.st.bit_index = nb;
        if (nb != '0) begin
          r.st.phase = PH_RD0_L;
        end else begin
          r.st.low_byte = s.shift_byte;
          r.st = start_byte(r.st, PH_RD1_L, 8'h00);
        end
      end
      PH_RD1_H: begin
        r.st.bit_index = nb;
        if (nb != '0) begin
          r.st.phase = PH_RD1_L;
        end else begin
          r.done = 1'b1;
          r.st.phase = PH_R1L;
        end
      end
      default: r.st.phase = PH_R1L;
    endcase
    return r;
  endfunction

  // pass through up to SkipDepth timed parts that are already complete
  function automatic skip_t skip_all(input seq_state_t s, input cfg_t c);
    skip_t r;
    skip_t a;
    r.st = s;
    r.done = 1'b0;
    for (int i = 0; i < SkipDepth; i++) begin
      if (r.st.phase != PH_R1P && r.st.phase != PH_R2P &&
          r.st.tick_count >= phase_len(r.st, c)) begin
        a = advance(r.st);
        r.st = a.st;
        r.done = r.done | a.done;
      end
    end
    return r;
  endfunction

  // floor((raw * 10 + 8) / 16)
  function automatic logic [15:0] raw_to_tenths(input logic [15:0] raw);
    logic [19:0] sum;
    sum = {1'b0, raw, 3'b000} + {3'b000, raw, 1'b0} + 20'd8;
    return sum[19:4];
  endfunction

  always_comb begin
    stepped = st;
    if (st.phase == PH_RD0_S || st.phase == PH_RD1_S) begin
      stepped.shift_byte = {bus_level, st.shift_byte[7:1]};
    end
    pres_adv = advance(stepped);
    if (st.phase == PH_R1P || st.phase == PH_R2P) begin
      if (!bus_level) stepped = pres_adv.st;
    end else begin
      stepped.tick_count = st.tick_count + TickW'(1);
    end
    chain_in = ctrl.settle ? st : stepped;
    chain = skip_all(chain_in, cfg);
    cand = raw_to_tenths({chain_in.shift_byte, chain_in.low_byte});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_R1L;
      st.tick_count <= '0;
      st.bit_index <= '0;
      st.shift_byte <= '0;
      st.low_byte <= '0;
      held <= '0;
      pending <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      if (ctrl.take || ctrl.settle) begin
        st <= chain.st;
        if (chain.done) held <= cand;
      end
      if (ctrl.settle && chain.done) begin
        pending <= 1'b1;
      end else if (ctrl.take) begin
        pending <= 1'b0;
      end
      if (ctrl.take) begin
        a_valid <= 1'b1;
      end else if (a_ready) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      a_res.drive_low <= drives_low(st.phase);
      a_res.reading_valid <= pending | chain.done;
      a_res.tenths_value <= chain.done ? cand : held;
    end
  end

endmodule

@@ design/owtr_digits.sv @@
// two-stage decimal split of the held reading and the result register
module owtr_digits (
  input  logic                clk,
  input  logic                rst,
  input  logic                a_valid,
  input  owtr_pkg::tick_res_t a_res,
  output logic                a_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                drive_low,
  output logic                reading_valid,
  output logic [15:0]         tenths_value,
  output logic [8:0]          tens_part,
  output logic [3:0]          units_digit,
  output logic [3:0]          tenths_digit
);
  import owtr_pkg::*;

  tick_res_t   b_res;
  logic [8:0]  b_tens;
  logic        b_valid;
  logic        b_ready;
  logic        c_ready;
  logic [28:0] prod;
  logic [15:0] hundreds;
  logic [15:0] diff;
  logic [7:0]  split;

  assign c_ready = !out_valid || out_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = b_ready;

  // reciprocal multiply, exact for values below 43690
  assign prod = 29'(a_res.tenths_value) * 29'(DivHundredMul);

  assign hundreds = 16'({b_tens, 6'b0}) + 16'({b_tens, 5'b0}) + 16'({b_tens, 2'b0});
  assign diff = b_res.tenths_value - hundreds;
  assign split = digit_split(diff[6:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_ready) b_valid <= a_valid;
      if (c_ready) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_res <= a_res;
      b_tens <= prod[27:19];
    end
    if (c_ready && b_valid) begin
      drive_low <= b_res.drive_low;
      reading_valid <= b_res.reading_valid;
      tenths_value <= b_res.tenths_value;
      tens_part <= b_tens;
      units_digit <= split[7:4];
      tenths_digit <= split[3:0];
    end
  end

endmodule

@@ design/onewire_temperature_reader.sv @@
// top level of the one-wire temperature reader: registers, handshakes, sequencer and digits
//
// One-wire bus master for a single sensor. Each input request is one bus tick carrying the
// sampled line level; each one yields one result request with the line drive for that tick,
// a one-tick pulse when a fresh reading completes, and the held reading in tenths with its
// decimal split. The block runs reset, presence, skip-ROM, convert, conversion wait, reset,
// presence, skip-ROM, read-scratchpad and a two-byte read, over and over. It takes one tick
// per clock unless output back-pressure or configuration writes hold it off; a result reaches
// the outputs behind the sequencer register and two digit stages. After a run of configuration
// writes the first tick offered is held off while the sequencer re-checks its running part
// against the new lengths.
module onewire_temperature_reader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [23:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          bus_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          drive_low,
  output logic                          reading_valid,
  output logic [15:0]                   tenths_value,
  output logic [8:0]                    tens_part,
  output logic [3:0]                    units_digit,
  output logic [3:0]                    tenths_digit
);
  import owtr_pkg::*;

  cfg_t      cfg;
  logic      cfg_changed;
  logic      settle;
  seq_ctrl_t ctrl;
  logic      a_valid;
  logic      a_ready;
  tick_res_t a_res;

  assign cfg_ready = 1'b1;
  // re-check only once the writes are over and a tick is waiting
  assign settle = cfg_changed && in_valid && !cfg_valid;
  assign in_ready = (!a_valid || a_ready) && !cfg_changed && !cfg_valid;
  assign ctrl.take = in_valid && in_ready;
  assign ctrl.settle = settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks <= 16'd80;
      cfg.presence_delay_ticks <= 16'd4;
      cfg.post_presence_ticks <= 16'd70;
      cfg.slot_ticks <= 16'd8;
      cfg.sample_delay_ticks <= 8'd2;
      cfg.conversion_wait_ticks <= 24'd1000000;
      cfg_changed <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_changed <= 1'b1;
      end else if (settle) begin
        cfg_changed <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RESET_LOW: cfg.reset_low_ticks <= cfg_data[15:0];
          CFG_PRESENCE_DELAY: cfg.presence_delay_ticks <= cfg_data[15:0];
          CFG_POST_PRESENCE: cfg.post_presence_ticks <= cfg_data[15:0];
          CFG_SLOT: cfg.slot_ticks <= cfg_data[15:0];
          CFG_SAMPLE_DELAY: cfg.sample_delay_ticks <= cfg_data[7:0];
          CFG_CONVERSION_WAIT: cfg.conversion_wait_ticks <= cfg_data;
          default: cfg <= cfg;
        endcase
      end
    end
  end

  owtr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .bus_level (bus_level),
    .a_ready   (a_ready),
    .a_valid   (a_valid),
    .a_res     (a_res)
  );

  owtr_digits u_digits (
    .clk           (clk),
    .rst           (rst),
    .a_valid       (a_valid),
    .a_res         (a_res),
    .a_ready       (a_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_low     (drive_low),
    .reading_valid (reading_valid),
    .tenths_value  (tenths_value),
    .tens_part     (tens_part),
    .units_digit   (units_digit),
    .tenths_digit  (tenths_digit)
  );

endmodule
